// ===== design/lcbc_pkg.sv =====
`timescale 1ns / 1ps

package lcbc_pkg;

   // Channel count and sample width of the learned color box.
   localparam int CHANNELS    = 3;
   localparam int SAMPLE_BITS = 16;

   // Fixed widths of the stream fields.
   localparam int CHAN_W      = 16;
   localparam int NUM_FIELDS  = 3;
   localparam int MODE_W      = 2;

   // Channels that hold a box: at most three fields exist per pixel.
   localparam int STORED      = (CHANNELS < NUM_FIELDS) ? CHANNELS : NUM_FIELDS;

   // Full scale is the byte value 255 placed in the top byte of a sample.
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE =
      SAMPLE_BITS'(255) << (SAMPLE_BITS - 8);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [CHAN_W-1:0]      chan_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR    = 2'd0,
      MODE_LEARN    = 2'd1,
      MODE_CLASSIFY = 2'd2
   } mode_type;

   typedef enum logic {
      REG_OUTPUT_STYLE    = 1'b0,
      REG_CHANNELS_IN_USE = 1'b1
   } reg_index_type;

   // Box update commands broadcast to every lane.
   typedef struct packed {
      logic clear;
      logic learn;
      logic seed;
   } lane_ctrl_type;

   // Settings and pixel flags the merge stage needs.
   typedef struct packed {
      logic       eliminate;
      logic [1:0] used;
      logic       masked;
      logic       box_valid;
   } merge_ctrl_type;

endpackage

// ===== design/lcbc_lane.sv =====
`timescale 1ns / 1ps

module lcbc_lane
   import lcbc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  sample_type    sample,
   output logic          in_range
);

   sample_type box_min_ff, box_min_in;
   sample_type box_max_ff, box_max_in;

   always_comb begin
      box_min_in = box_min_ff;
      box_max_in = box_max_ff;
      if (ctrl.clear) begin
         box_min_in = '0;
         box_max_in = '0;
      end else if (ctrl.learn) begin
         if (ctrl.seed || sample < box_min_ff) begin
            box_min_in = sample;
         end
         if (ctrl.seed || sample > box_max_ff) begin
            box_max_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_ff <= '0;
         box_max_ff <= '0;
      end else begin
         box_min_ff <= box_min_in;
         box_max_ff <= box_max_in;
      end
   end

   assign in_range = (sample >= box_min_ff) && (sample <= box_max_ff);

endmodule

// ===== design/lcbc_merge.sv =====
`timescale 1ns / 1ps

module lcbc_merge
   import lcbc_pkg::*;
(
   input  merge_ctrl_type ctrl,
   input  logic [STORED-1:0] in_range,
   input  sample_type     sample [STORED],
   output logic           written,
   output logic           in_box,
   output chan_type       out_chan [NUM_FIELDS]
);

   logic [STORED-1:0] lane_used;
   logic              all_in;

   always_comb begin
      for (int c = 0; c < STORED; c++) begin
         lane_used[c] = (2'(c) < ctrl.used);
      end
      all_in = &(in_range | ~lane_used);
      written = ctrl.masked;
      in_box  = ctrl.masked && ctrl.box_valid && all_in;
      for (int c = 0; c < NUM_FIELDS; c++) begin
         out_chan[c] = '0;
      end
      for (int c = 0; c < STORED; c++) begin
         if (ctrl.masked && lane_used[c]) begin
            if (ctrl.eliminate) begin
               out_chan[c] = CHAN_W'(in_box ? sample[c] : FULL_SCALE);
            end else begin
               out_chan[c] = CHAN_W'(in_box ? FULL_SCALE : sample_type'(0));
            end
         end
      end
   end

endmodule

// ===== design/learned_color_box_classifier_unit.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// req      in         req_tvalid/req_tready    tdata: chan_a, chan_b, chan_c; tuser: mode, mask_on
// rsp      out        rsp_tvalid/rsp_tready    tdata: out_a, out_b, out_c; tuser: written, inside_box
// csr      in         csr_valid/csr_ready      csr_index, csr_data
//
// One word is accepted per cycle unless the input stalls; a classify word gives its result word
// in the next cycle. The per-channel compare in the lanes feeds the result register.
// Reset empties the box and loads output_style = 0, channels_in_use = 3.
// While a result waits, a new word is taken only in a cycle where the result leaves.
// Clear and learn words never produce a result, but they too wait behind a held result.
module learned_color_box_classifier_unit
   import lcbc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // chan_a [15:0], chan_b [31:16], chan_c [47:32]
   input  logic [2:0]  req_tuser,   // mode [1:0], mask_on [2]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_a [15:0], out_b [31:16], out_c [47:32]
   output logic [1:0]  rsp_tuser,   // written [0], inside_box [1]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);

   // Configuration registers.
   logic       style_ff, style_in;
   logic [1:0] chans_ff, chans_in;

   // Box occupancy, shared by all lanes.
   logic box_valid_ff, box_valid_in;

   // Result register.
   logic     rsp_valid_ff, rsp_valid_in;
   logic     written_ff, inside_ff;
   chan_type out_ff [NUM_FIELDS];

   logic       req_accept;
   mode_type   mode;
   logic       masked;
   chan_type   chan [NUM_FIELDS];
   sample_type sample [STORED];
   logic [STORED-1:0] in_range;
   logic [1:0] used;

   lane_ctrl_type  lane_ctrl;
   merge_ctrl_type merge_ctrl;
   logic     m_written, m_inside;
   chan_type m_out [NUM_FIELDS];

   // The input side stalls only while a finished result is held and not taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign mode   = mode_type'(req_tuser[1:0]);
   assign masked = req_tuser[2];

   always_comb begin
      for (int c = 0; c < NUM_FIELDS; c++) begin
         chan[c] = req_tdata[c*CHAN_W +: CHAN_W];
      end
      // Bits above the sample width are dropped.
      for (int c = 0; c < STORED; c++) begin
         sample[c] = chan[c][SAMPLE_BITS-1:0];
      end
   end

   // A channel count of zero acts as one; counts past the stored lanes are limited.
   always_comb begin
      used = chans_ff;
      if (used == 2'd0) begin
         used = 2'd1;
      end
      if (used > 2'(STORED)) begin
         used = 2'(STORED);
      end
   end

   always_comb begin
      lane_ctrl.clear = req_accept && (mode == MODE_CLEAR);
      lane_ctrl.learn = req_accept && (mode == MODE_LEARN) && masked;
      lane_ctrl.seed  = !box_valid_ff;
   end

   genvar g;
   generate
      for (g = 0; g < STORED; g++) begin : g_lane
         lcbc_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (lane_ctrl),
            .sample   (sample[g]),
            .in_range (in_range[g])
         );
      end
   endgenerate

   always_comb begin
      merge_ctrl.eliminate = style_ff;
      merge_ctrl.used      = used;
      merge_ctrl.masked    = masked;
      merge_ctrl.box_valid = box_valid_ff;
   end

   lcbc_merge u_merge (
      .ctrl     (merge_ctrl),
      .in_range (in_range),
      .sample   (sample),
      .written  (m_written),
      .in_box   (m_inside),
      .out_chan (m_out)
   );

   // Box occupancy: a clear empties the box, a masked learn sample fills it.
   always_comb begin
      box_valid_in = box_valid_ff;
      if (lane_ctrl.clear) begin
         box_valid_in = 1'b0;
      end else if (lane_ctrl.learn) begin
         box_valid_in = 1'b1;
      end
   end

   // Configuration writes.
   always_comb begin
      style_in = style_ff;
      chans_in = chans_ff;
      if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_OUTPUT_STYLE:    style_in = csr_data[0];
            REG_CHANNELS_IN_USE: chans_in = csr_data;
            default: ;
         endcase
      end
   end

   // Result register: loads on a classify word, drains when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept && (mode == MODE_CLASSIFY)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         style_ff     <= 1'b0;
         chans_ff     <= 2'd3;
         box_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         style_ff     <= style_in;
         chans_ff     <= chans_in;
         box_valid_ff <= box_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (mode == MODE_CLASSIFY)) begin
         written_ff <= m_written;
         inside_ff  <= m_inside;
         for (int c = 0; c < NUM_FIELDS; c++) begin
            out_ff[c] <= m_out[c];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {inside_ff, written_ff};
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};

   // An unmasked pixel gives an all-zero result.
   a_unmasked_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !written_ff) |-> (!inside_ff && rsp_tdata == '0))
      else $error("unmasked result carries nonzero payload");

   // Inside the box implies the pixel was written.
   a_inside_written : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && inside_ff) |-> written_ff)
      else $error("inside flag without written flag");

   // A clear word always leaves the box empty.
   a_clear_empties : assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode == MODE_CLEAR) |=> !box_valid_ff)
      else $error("box still valid after clear");

   // A masked learn word always leaves the box occupied.
   a_learn_fills : assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode == MODE_LEARN && masked) |=> box_valid_ff)
      else $error("box empty after masked learn");

endmodule

// ===== bench/learned_color_box_classifier_unit_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the learned color box classifier. Pixel words are
// driven on the req stream; every accepted word also runs through a local
// predictor that keeps its own copy of the box and the settings. Classify
// words push an expected result word, and the rsp side is checked in order.
module learned_color_box_classifier_unit_test;
   import lcbc_pkg::*;

   // Mode code that the block must ignore (no box change, no result word).
   localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

   // Idle cycles with no handshake at all before the run is declared hung.
   // The longest deliberate stall is the receiver hold-off below.
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   // Cycles to let a result-free word finish before touching the registers.
   localparam int SETTLE_CYCLES = 4;
   localparam int RANDOM_WORDS  = 1650;
   localparam int MAX_REPORTS   = 40;

   typedef struct packed {
      logic               written;
      logic               in_box;
      chan_type [2:0]     chan;
   } pixel_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // chan_a [15:0], chan_b [31:16], chan_c [47:32]
   logic [2:0]  req_tuser;   // mode [1:0], mask_on [2]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // out_a [15:0], out_b [31:16], out_c [47:32]
   logic [1:0]  rsp_tuser;   // written [0], inside_box [1]
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [1:0]  csr_data;

   learned_color_box_classifier_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor state: the learned box and the two settings.
   sample_type box_lo [3];
   sample_type box_hi [3];
   logic       box_learned;
   logic       keep_inside;
   logic [1:0] channel_setting;

   pixel_result_type expected_pixels [$];
   int error_count;
   int words_sent;
   int gap_limit;
   int hold_request;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Number of channels that take part in the compare and in the output.
   function automatic int channels_compared();
      int n;
      n = int'(channel_setting);
      if (n == 0) n = 1;
      if (n > STORED) n = STORED;
      return n;
   endfunction

   // Applies one accepted pixel word to the local box and, for a classify
   // word, queues the result word the block must return.
   task automatic predict_word(input logic [1:0] mode, input logic mask,
                               input chan_type a, input chan_type b, input chan_type c);
      sample_type       px [3];
      pixel_result_type res;
      logic             hit;
      int               n;
      px[0] = a[SAMPLE_BITS-1:0];
      px[1] = b[SAMPLE_BITS-1:0];
      px[2] = c[SAMPLE_BITS-1:0];
      case (mode)
         MODE_CLEAR: begin
            for (int i = 0; i < 3; i++) begin
               box_lo[i] = '0;
               box_hi[i] = '0;
            end
            box_learned = 1'b0;
         end
         MODE_LEARN: begin
            if (mask) begin
               // The first sample after an empty box seeds it; later ones widen it.
               for (int i = 0; i < STORED; i++) begin
                  if (!box_learned) begin
                     box_lo[i] = px[i];
                     box_hi[i] = px[i];
                  end else begin
                     if (px[i] < box_lo[i]) box_lo[i] = px[i];
                     if (px[i] > box_hi[i]) box_hi[i] = px[i];
                  end
               end
               box_learned = 1'b1;
            end
         end
         MODE_CLASSIFY: begin
            res = '0;
            if (mask) begin
               n   = channels_compared();
               hit = box_learned;
               for (int i = 0; i < n; i++)
                  if (px[i] < box_lo[i] || px[i] > box_hi[i]) hit = 1'b0;
               res.written = 1'b1;
               res.in_box  = hit;
               for (int i = 0; i < n; i++) begin
                  if (keep_inside)
                     res.chan[i] = hit ? chan_type'(px[i]) : chan_type'(FULL_SCALE);
                  else
                     res.chan[i] = hit ? chan_type'(FULL_SCALE) : '0;
               end
            end
            expected_pixels.push_back(res);
         end
         default: begin
            // The unused mode code leaves everything as it is.
         end
      endcase
   endtask

   // Offers one pixel word after a random gap and returns once it is taken.
   // The valid line is only lowered when a gap is drawn, so back-to-back words
   // never see a low and a high assigned in the same step.
   task automatic send_word(input logic [1:0] mode, input logic mask,
                            input chan_type a, input chan_type b, input chan_type c);
      int gap;
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      req_tuser  <= {mask, mode};
      do @(posedge clock); while (!req_tready);
      predict_word(mode, mask, a, b, c);
      words_sent++;
   endtask

   // Stops offering, waits until every expected word has come back, and then
   // gives a result-free word time to land in the box.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back; only called while the block is idle.
   task automatic configure(input logic style, input logic [1:0] count);
      csr_valid <= 1'b1;
      csr_index <= REG_OUTPUT_STYLE;
      csr_data  <= {1'b0, style};
      do @(posedge clock); while (!csr_ready);
      keep_inside = style;
      csr_index <= REG_CHANNELS_IN_USE;
      csr_data  <= count;
      do @(posedge clock); while (!csr_ready);
      channel_setting = count;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string field, input int got, input int want);
      if (error_count < MAX_REPORTS)
         $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      error_count++;
   endtask

   // Value for a classify channel, aimed mostly inside the box and at and just beyond its edges.
   function automatic chan_type probe_value(input int lo, input int hi);
      int v;
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2, 3, 4: v = $urandom_range(hi, lo);
         5:             v = lo;
         6:             v = hi;
         7:             v = lo - 1;
         8:             v = hi + 1;
         default:       v = $urandom_range(0, 65535);
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return chan_type'(v);
   endfunction

   // Learn sample drawn from a cluster, so boxes have realistic sizes.
   function automatic chan_type cluster_value(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(0, spread)) - spread / 2;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return chan_type'(v);
   endfunction

   task automatic send_probe();
      send_word(MODE_CLASSIFY, 1'b1, probe_value(int'(box_lo[0]), int'(box_hi[0])),
                probe_value(int'(box_lo[1]), int'(box_hi[1])),
                probe_value(int'(box_lo[2]), int'(box_hi[2])));
   endtask

   // Reset contents: empty box, trace style, all three channels.
   task automatic test_empty_box();
      send_word(MODE_CLASSIFY, 1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(MODE_CLASSIFY, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(MODE_IGNORED,  1'b1, 16'h1234, 16'h5678, 16'h9ABC);
      send_word(MODE_LEARN,    1'b0, 16'h1000, 16'h2000, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h1000, 16'h2000, 16'h3000);
   endtask

   // Seeding, edges of a one-point box, widening, and clearing.
   task automatic test_learn_and_clear();
      send_word(MODE_LEARN,    1'b1, 16'h1000, 16'h2000, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h1000, 16'h2000, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0FFF, 16'h2000, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h1000, 16'h2000, 16'h3001);
      send_word(MODE_LEARN,    1'b1, 16'h0000, 16'hFFFF, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0000, 16'hFFFF, 16'h3000);
      send_word(MODE_CLASSIFY, 1'b1, 16'hFFFF, 16'h8000, 16'h3000);
      send_word(MODE_CLEAR,    1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(MODE_LEARN,    1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(MODE_LEARN,    1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(MODE_CLASSIFY, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
   endtask

   // Eliminate style with channel counts one, zero (meaning one channel) and two, then the other style with three.
   task automatic test_styles_and_channels();
      settle();
      configure(1'b1, 2'd1);
      send_word(MODE_CLEAR,    1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(MODE_LEARN,    1'b1, 16'h0100, 16'h0100, 16'h0100);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0100, 16'hFFFF, 16'hFFFF);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0101, 16'h0100, 16'h0100);
      settle();
      configure(1'b1, 2'd0);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0100, 16'h0000, 16'hFFFF);
      settle();
      configure(1'b1, 2'd2);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0100, 16'h0100, 16'hFFFF);
      settle();
      configure(1'b0, 2'd3);
      send_word(MODE_CLASSIFY, 1'b1, 16'h0100, 16'h0100, 16'h0100);
   endtask

   // Random phases, each under its own settings. Most words form a sensible
   // sequence: clear, a few learn samples from one cluster, then classify
   // words around the box. The rest is noise of every mode and mask.
   task automatic test_random_traffic();
      int         start;
      int         phase;
      int         center [3];
      int         spread;
      int         r;
      logic       style;
      logic [1:0] count;
      start = words_sent;
      phase = 0;
      while (words_sent - start < RANDOM_WORDS) begin
         settle();
         case (phase)
            0:       begin style = 1'b0; count = 2'd3; end
            1:       begin style = 1'b1; count = 2'd1; end
            2:       begin style = 1'b1; count = 2'd0; end
            3:       begin style = 1'b0; count = 2'd2; end
            default: begin
               style = 1'($urandom_range(0, 1));
               count = 2'($urandom_range(0, 3));
            end
         endcase
         configure(style, count);
         // Every fourth phase runs with neither side idling.
         gap_limit = (phase % 4 == 3) ? 0 : 4;
         for (int i = 0; i < 3; i++) center[i] = $urandom_range(0, 65535);
         spread = (1 << $urandom_range(0, 16)) - 1;
         send_word(MODE_CLEAR, 1'($urandom_range(0, 1)), chan_type'($urandom),
                   chan_type'($urandom), chan_type'($urandom));
         repeat ($urandom_range(1, 4))
            send_word(MODE_LEARN, 1'b1, cluster_value(center[0], spread),
                      cluster_value(center[1], spread), cluster_value(center[2], spread));
         repeat ($urandom_range(60, 140)) begin
            r = $urandom_range(0, 99);
            if (r < 3)
               send_word(MODE_CLEAR, 1'($urandom_range(0, 1)), chan_type'($urandom),
                         chan_type'($urandom), chan_type'($urandom));
            else if (r < 12)
               send_word(MODE_LEARN, 1'b1, cluster_value(center[0], spread),
                         cluster_value(center[1], spread), cluster_value(center[2], spread));
            else if (r < 15)
               send_word(MODE_LEARN, 1'b0, chan_type'($urandom), chan_type'($urandom),
                         chan_type'($urandom));
            else if (r < 20)
               send_word(MODE_CLASSIFY, 1'b0, chan_type'($urandom), chan_type'($urandom),
                         chan_type'($urandom));
            else if (r < 25)
               send_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         chan_type'($urandom), chan_type'($urandom), chan_type'($urandom));
            else
               send_probe();
         end
         phase++;
      end
   endtask

   // The receiver stops for a long stretch while words keep coming, so the
   // result register fills and the input has to stall.
   task automatic test_backpressure();
      settle();
      gap_limit = 0;
      send_word(MODE_LEARN, 1'b1, 16'h4000, 16'h4000, 16'h4000);
      send_word(MODE_LEARN, 1'b1, 16'hC000, 16'hC000, 16'hC000);
      hold_request = HOLD_CYCLES;
      repeat (40) send_probe();
      gap_limit = 4;
   endtask

   // Receiver: draws a stall before each word, or takes a requested hold-off.
   initial begin : receiver
      int stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end else begin
            stall = $urandom_range(0, gap_limit);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result check: each accepted word against the oldest expectation.
   always @(posedge clock) begin : result_check
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected word", int'(rsp_tdata[15:0]), 0);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_tuser[0] !== want.written)
               report_mismatch("written", int'(rsp_tuser[0]), int'(want.written));
            if (rsp_tuser[1] !== want.in_box)
               report_mismatch("inside_box", int'(rsp_tuser[1]), int'(want.in_box));
            for (int i = 0; i < 3; i++)
               if (rsp_tdata[i*16 +: 16] !== want.chan[i])
                  report_mismatch($sformatf("out channel %0d", i),
                                  int'(rsp_tdata[i*16 +: 16]), int'(want.chan[i]));
         end
      end
   end

   // Watchdog: a run that stops moving for too long has hung.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_OUTPUT_STYLE;
      csr_data   <= '0;
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = '0;
         box_hi[i] = '0;
      end
      box_learned     = 1'b0;
      keep_inside     = 1'b0;
      channel_setting = 2'd3;
      error_count     = 0;
      words_sent      = 0;
      gap_limit       = 4;
      hold_request    = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_box();
      test_learn_and_clear();
      test_styles_and_channels();
      test_random_traffic();
      test_backpressure();

      settle();
      repeat (10) @(posedge clock);
      if (expected_pixels.size() != 0)
         report_mismatch("words never returned", 0, expected_pixels.size());
      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
